>>> rtl/tda_pkg.sv
// tda_pkg: shared constants, types and helpers of the transform delta apply block.
// Used by every module under rtl/; depends on nothing.
package tda_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int STEP_BITS  = 31;
    localparam int NUM_BITS   = 33;  // snap numerator 2|v| + step
    localparam int SC_BITS    = 33;  // CORDIC datapath
    localparam int CORDIC_STEPS = 20;
    localparam int RED_STEPS  = 8;   // quotient bits of the modulo-360 reduction
    localparam int SNAP_LAT   = NUM_BITS + 1;
    localparam int TRIG_LAT   = RED_STEPS + CORDIC_STEPS + 2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_SPACE = 3'd1;
    localparam logic [2:0] REG_AXIS  = 3'd2;
    localparam logic [2:0] REG_MOVE  = 3'd3;
    localparam logic [2:0] REG_TURN  = 3'd4;
    localparam logic [2:0] REG_GROW  = 3'd5;

    // Mode codes; the unused code behaves as scale
    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_ROTATE    = 2'd1;
    localparam logic [1:0] MODE_SCALE     = 2'd2;

    localparam logic [2:0] AXIS_ALL = 3'd7;

    localparam word_t WORD_MAX = 32'sh7fff_ffff;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    // Angles in degrees, Q16.16
    localparam word_t FULL_DEG    = 32'sd23592960;
    localparam word_t HALF_DEG    = 32'sd11796480;
    localparam word_t QUARTER_DEG = 32'sd5898240;
    // Multiple of a full turn that lifts any word to a non-negative value
    localparam logic [32:0] RED_OFFSET = 33'd2170552320;

    localparam logic signed [SC_BITS-1:0] GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        word_t c;
        word_t s;
    } sc_t;

    function automatic logic signed [31:0] atan_deg(input int unsigned idx);
        logic signed [31:0] r;
        case (idx)
            0:  r = 32'sd2949120;
            1:  r = 32'sd1740967;
            2:  r = 32'sd919879;
            3:  r = 32'sd466945;
            4:  r = 32'sd234379;
            5:  r = 32'sd117304;
            6:  r = 32'sd58666;
            7:  r = 32'sd29335;
            8:  r = 32'sd14668;
            9:  r = 32'sd7334;
            10: r = 32'sd3667;
            11: r = 32'sd1833;
            12: r = 32'sd917;
            13: r = 32'sd458;
            14: r = 32'sd229;
            15: r = 32'sd115;
            16: r = 32'sd57;
            17: r = 32'sd29;
            18: r = 32'sd14;
            19: r = 32'sd7;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic word_t sat_word(input logic signed [67:0] v);
        word_t r;
        if (v > 68'(WORD_MAX)) begin
            r = WORD_MAX;
        end else if (v < 68'(WORD_MIN)) begin
            r = WORD_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q2.30 product, rounded half up
    function automatic logic signed [32:0] mul30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        p = (66'(a) * 66'(b)) + 66'sd536870912;
        p = p >>> 30;
        return p[32:0];
    endfunction

endpackage

>>> rtl/tda_div_cell.sv
// tda_div_cell: one restoring remainder step of the snap divider.
// Uses tda_pkg widths.
module tda_div_cell #(
    parameter int BIT = 0
) (
    input  logic                         aclk,
    input  logic                         en,
    input  tda_pkg::word_t               v_in,
    input  logic [tda_pkg::NUM_BITS-1:0] num_in,
    input  logic [31:0]                  rem_in,
    input  logic [31:0]                  d,
    output tda_pkg::word_t               v_out,
    output logic [tda_pkg::NUM_BITS-1:0] num_out,
    output logic [31:0]                  rem_out
);

    tda_pkg::word_t               v_reg;
    logic [tda_pkg::NUM_BITS-1:0] num_reg;
    logic [31:0]                  rem_reg;
    logic [31:0]                  rem_next;
    logic [32:0]                  sh;
    logic [32:0]                  diff;

    always_comb begin
        sh   = {rem_in, num_in[BIT]};
        diff = sh - {1'b0, d};
        rem_next = (sh >= {1'b0, d}) ? diff[31:0] : sh[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg   <= v_in;
            num_reg <= num_in;
            rem_reg <= rem_next;
        end
    end

    assign v_out   = v_reg;
    assign num_out = num_reg;
    assign rem_out = rem_reg;

endmodule

>>> rtl/tda_snap_lane.sv
// tda_snap_lane: snaps one delta to a step, round half away from zero, saturated.
// Chain of tda_div_cell computes (2|v|+step) mod 2step; uses tda_pkg.
module tda_snap_lane (
    input  logic                          aclk,
    input  logic                          en,
    input  tda_pkg::word_t                v_in,
    input  logic [tda_pkg::STEP_BITS-1:0] step,
    output tda_pkg::word_t                snap_out
);

    localparam int NB = tda_pkg::NUM_BITS;

    tda_pkg::word_t v_w   [0:NB];
    logic [NB-1:0]  num_w [0:NB];
    logic [31:0]    rem_w [0:NB];
    logic [31:0]    mag;
    logic [31:0]    d;
    logic [NB-1:0]  rdiff;
    logic [31:0]    r;
    tda_pkg::word_t snap_reg;
    tda_pkg::word_t snap_next;

    always_comb begin
        mag = v_in[31] ? 32'(~v_in + 32'sd1) : 32'(v_in);
        d   = {step, 1'b0};
    end

    assign v_w[0]   = v_in;
    assign num_w[0] = {mag, 1'b0} + NB'(step);
    assign rem_w[0] = '0;

    for (genvar k = 0; k < NB; k++) begin : g_cell
        tda_div_cell #(.BIT(NB - 1 - k)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .v_in    (v_w[k]),
            .num_in  (num_w[k]),
            .rem_in  (rem_w[k]),
            .d       (d),
            .v_out   (v_w[k+1]),
            .num_out (num_w[k+1]),
            .rem_out (rem_w[k+1])
        );
    end

    // q*step = (num - rem) / 2
    always_comb begin
        rdiff = num_w[NB] - {1'b0, rem_w[NB]};
        r     = rdiff[NB-1:1];
        priority if (step == '0) begin
            snap_next = v_w[NB];
        end else if (v_w[NB][31]) begin
            snap_next = (r > 32'h8000_0000) ? tda_pkg::WORD_MIN : tda_pkg::word_t'(~r + 32'd1);
        end else begin
            snap_next = (r > 32'h7fff_ffff) ? tda_pkg::WORD_MAX : tda_pkg::word_t'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_out = snap_reg;

endmodule

>>> rtl/tda_cordic_cell.sv
// tda_cordic_cell: one rotation step of the degree-domain CORDIC.
// Arctangent table from tda_pkg.
module tda_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [tda_pkg::SC_BITS-1:0] x_in,
    input  logic signed [tda_pkg::SC_BITS-1:0] y_in,
    input  tda_pkg::word_t                     z_in,
    input  logic                               flip_in,
    output logic signed [tda_pkg::SC_BITS-1:0] x_out,
    output logic signed [tda_pkg::SC_BITS-1:0] y_out,
    output tda_pkg::word_t                     z_out,
    output logic                               flip_out
);

    logic signed [tda_pkg::SC_BITS-1:0] x_reg, y_reg, x_next, y_next;
    tda_pkg::word_t                     z_reg, z_next;
    logic                               flip_reg;

    always_comb begin
        if (!z_in[31]) begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - tda_pkg::atan_deg(STEP);
        end else begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + tda_pkg::atan_deg(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            flip_reg <= flip_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign flip_out = flip_reg;

endmodule

>>> rtl/tda_sincos.sv
// tda_sincos: cosine and sine in Q2.30 of an angle in Q16.16 degrees.
// Modulo-360 reduction, quadrant fold, then a chain of tda_cordic_cell; uses tda_pkg.
module tda_sincos (
    input  logic           aclk,
    input  logic           en,
    input  tda_pkg::word_t deg_in,
    output tda_pkg::sc_t   sc_out
);

    localparam int SB = tda_pkg::SC_BITS;
    localparam int RS = tda_pkg::RED_STEPS;
    localparam int CS = tda_pkg::CORDIC_STEPS;

    logic [32:0]            red_reg [0:RS-1];
    logic [32:0]            red_in  [0:RS-1];
    tda_pkg::word_t         a0, a1, z_next;
    logic                   flip_next;
    tda_pkg::word_t         z0_reg;
    logic                   flip0_reg;
    logic signed [SB-1:0]   x_w [0:CS];
    logic signed [SB-1:0]   y_w [0:CS];
    tda_pkg::word_t         z_w [0:CS];
    logic                   f_w [0:CS];
    tda_pkg::sc_t           sc_reg, sc_next;
    logic signed [SB-1:0]   cx;

    // Subtract full turns scaled by 2^7 down to 2^0
    for (genvar j = 0; j < RS; j++) begin : g_red
        logic [32:0] sub;
        if (j == 0) begin : g_first
            assign red_in[j] = {deg_in[31], deg_in} + tda_pkg::RED_OFFSET;
        end else begin : g_next
            assign red_in[j] = red_reg[j-1];
        end
        assign sub = 33'(tda_pkg::FULL_DEG) << (RS - 1 - j);
        always_ff @(posedge aclk) begin
            if (en) begin
                red_reg[j] <= (red_in[j] >= sub) ? red_in[j] - sub : red_in[j];
            end
        end
    end

    always_comb begin
        a0 = tda_pkg::word_t'({7'b0, red_reg[RS-1][24:0]});
        a1 = (a0 > tda_pkg::HALF_DEG) ? a0 - tda_pkg::FULL_DEG : a0;
        priority if (a1 > tda_pkg::QUARTER_DEG) begin
            z_next    = tda_pkg::HALF_DEG - a1;
            flip_next = 1'b1;
        end else if (a1 < -tda_pkg::QUARTER_DEG) begin
            z_next    = -tda_pkg::HALF_DEG - a1;
            flip_next = 1'b1;
        end else begin
            z_next    = a1;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg    <= z_next;
            flip0_reg <= flip_next;
        end
    end

    assign x_w[0] = tda_pkg::GAIN_Q30;
    assign y_w[0] = '0;
    assign z_w[0] = z0_reg;
    assign f_w[0] = flip0_reg;

    for (genvar k = 0; k < CS; k++) begin : g_cordic
        tda_cordic_cell #(.STEP(k)) u_cell (
            .aclk     (aclk),
            .en       (en),
            .x_in     (x_w[k]),
            .y_in     (y_w[k]),
            .z_in     (z_w[k]),
            .flip_in  (f_w[k]),
            .x_out    (x_w[k+1]),
            .y_out    (y_w[k+1]),
            .z_out    (z_w[k+1]),
            .flip_out (f_w[k+1])
        );
    end

    // Negate cosine for folded angles
    always_comb begin
        cx = f_w[CS] ? -x_w[CS] : x_w[CS];
        sc_next.c = cx[31:0];
        sc_next.s = y_w[CS][31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg <= sc_next;
        end
    end

    assign sc_out = sc_reg;

endmodule

>>> rtl/transform_delta_apply_top.sv
// transform_delta_apply_top: applies a masked, snapped delta to a start transform.
// Instantiates tda_snap_lane and tda_sincos; uses tda_pkg.
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    s_delta_*, s_start_loc_*, s_start_rot_*, s_start_scale_*
//  m_        out  m_valid/m_ready    m_new_loc_*, m_new_rot_*, m_new_scale_*
//  apb       in   psel/penable/...   mode, space, axis_mask, move/turn/grow_step
//
// One transaction per cycle unless the output stalls. From accept to result a
// transaction passes through the 33-cell remainder chain of the snap lanes plus
// its result stage and the matrix products and output stage that follow.
// The whole pipeline holds while the output register is full and not taken.
// aresetn is synchronous and active low; it empties the pipeline and loads
// register defaults (mode translate, world space, all axes, steps zero).
module transform_delta_apply_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_delta_x,
    input  logic signed [31:0] s_delta_y,
    input  logic signed [31:0] s_delta_z,
    input  logic signed [31:0] s_start_loc_x,
    input  logic signed [31:0] s_start_loc_y,
    input  logic signed [31:0] s_start_loc_z,
    input  logic signed [31:0] s_start_rot_x,
    input  logic signed [31:0] s_start_rot_y,
    input  logic signed [31:0] s_start_rot_z,
    input  logic signed [31:0] s_start_scale_x,
    input  logic signed [31:0] s_start_scale_y,
    input  logic signed [31:0] s_start_scale_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_new_loc_x,
    output logic signed [31:0] m_new_loc_y,
    output logic signed [31:0] m_new_loc_z,
    output logic signed [31:0] m_new_rot_x,
    output logic signed [31:0] m_new_rot_y,
    output logic signed [31:0] m_new_rot_z,
    output logic signed [31:0] m_new_scale_x,
    output logic signed [31:0] m_new_scale_y,
    output logic signed [31:0] m_new_scale_z
);

    localparam int SL    = tda_pkg::SNAP_LAT;   // snapped delta ready
    localparam int TL    = tda_pkg::TRIG_LAT;   // sine/cosine ready
    localparam int DEPTH = SL + 2;              // output stage
    localparam int SW    = tda_pkg::STEP_BITS;

    typedef struct packed {
        logic [2:0][31:0] loc;
        logic [2:0][31:0] rot;
        logic [2:0][31:0] scl;
    } xf_t;

    typedef logic signed [32:0] ent_t;

    // ---------------- configuration ----------------
    logic [1:0]    mode_reg;
    logic          space_reg;
    logic [2:0]    axis_reg;
    logic [SW-1:0] move_reg, turn_reg, grow_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= tda_pkg::MODE_TRANSLATE;
            space_reg <= 1'b0;
            axis_reg  <= tda_pkg::AXIS_ALL;
            move_reg  <= '0;
            turn_reg  <= '0;
            grow_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                tda_pkg::REG_MODE:  mode_reg  <= pwdata[1:0];
                tda_pkg::REG_SPACE: space_reg <= pwdata[0];
                tda_pkg::REG_AXIS:  axis_reg  <= pwdata[2:0];
                tda_pkg::REG_MOVE:  move_reg  <= pwdata[SW-1:0];
                tda_pkg::REG_TURN:  turn_reg  <= pwdata[SW-1:0];
                tda_pkg::REG_GROW:  grow_reg  <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tda_pkg::REG_MODE:  prdata = {30'b0, mode_reg};
            tda_pkg::REG_SPACE: prdata = {31'b0, space_reg};
            tda_pkg::REG_AXIS:  prdata = {29'b0, axis_reg};
            tda_pkg::REG_MOVE:  prdata = {1'b0, move_reg};
            tda_pkg::REG_TURN:  prdata = {1'b0, turn_reg};
            tda_pkg::REG_GROW:  prdata = {1'b0, grow_reg};
            default:            prdata = '0;
        endcase
    end

    logic is_trans, is_rot, is_scale;
    assign is_trans = (mode_reg == tda_pkg::MODE_TRANSLATE);
    assign is_rot   = (mode_reg == tda_pkg::MODE_ROTATE);
    assign is_scale = !is_trans && !is_rot;

    // ---------------- flow control ----------------
    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv     = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // ---------------- input: mask and snap ----------------
    tda_pkg::word_t  din [3];
    tda_pkg::word_t  dm  [3];
    tda_pkg::word_t  dsn [3];
    logic [SW-1:0]   step_sel;

    assign din[0] = s_delta_x;
    assign din[1] = s_delta_y;
    assign din[2] = s_delta_z;

    always_comb begin
        priority if (is_trans) begin
            step_sel = move_reg;
        end else if (is_rot) begin
            step_sel = turn_reg;
        end else begin
            step_sel = grow_reg;
        end
        for (int i = 0; i < 3; i++) begin
            if (is_scale && axis_reg == tda_pkg::AXIS_ALL) begin
                dm[i] = s_delta_x;
            end else begin
                dm[i] = axis_reg[i] ? din[i] : '0;
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_snap
        tda_snap_lane u_snap (
            .aclk     (aclk),
            .en       (adv),
            .v_in     (dm[i]),
            .step     (step_sel),
            .snap_out (dsn[i])
        );
    end

    // ---------------- sine and cosine ----------------
    tda_pkg::sc_t trig [3];
    tda_pkg::word_t rin [3];

    assign rin[0] = s_start_rot_x;
    assign rin[1] = s_start_rot_y;
    assign rin[2] = s_start_rot_z;

    for (genvar i = 0; i < 3; i++) begin : g_trig
        tda_sincos u_sincos (
            .aclk   (aclk),
            .en     (adv),
            .deg_in (rin[i]),
            .sc_out (trig[i])
        );
    end

    // ---------------- rotation matrix Rz*Ry*Rx ----------------
    ent_t sysx_reg, sycx_reg, czcy_reg, szcy_reg, cysx_reg, cycx_reg;
    ent_t szcx_reg, czcx_reg, szsx_reg, czsx_reg, sy_reg, cz_reg, sz_reg;
    ent_t m_reg  [9];
    ent_t ma_reg [9];
    ent_t mb_reg [9];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sysx_reg <= tda_pkg::mul30(33'(trig[1].s), 33'(trig[0].s));
            sycx_reg <= tda_pkg::mul30(33'(trig[1].s), 33'(trig[0].c));
            czcy_reg <= tda_pkg::mul30(33'(trig[2].c), 33'(trig[1].c));
            szcy_reg <= tda_pkg::mul30(33'(trig[2].s), 33'(trig[1].c));
            cysx_reg <= tda_pkg::mul30(33'(trig[1].c), 33'(trig[0].s));
            cycx_reg <= tda_pkg::mul30(33'(trig[1].c), 33'(trig[0].c));
            szcx_reg <= tda_pkg::mul30(33'(trig[2].s), 33'(trig[0].c));
            czcx_reg <= tda_pkg::mul30(33'(trig[2].c), 33'(trig[0].c));
            szsx_reg <= tda_pkg::mul30(33'(trig[2].s), 33'(trig[0].s));
            czsx_reg <= tda_pkg::mul30(33'(trig[2].c), 33'(trig[0].s));
            sy_reg   <= 33'(trig[1].s);
            cz_reg   <= 33'(trig[2].c);
            sz_reg   <= 33'(trig[2].s);

            m_reg[0] <= czcy_reg;
            m_reg[1] <= tda_pkg::mul30(cz_reg, sysx_reg) - szcx_reg;
            m_reg[2] <= tda_pkg::mul30(cz_reg, sycx_reg) + szsx_reg;
            m_reg[3] <= szcy_reg;
            m_reg[4] <= tda_pkg::mul30(sz_reg, sysx_reg) + czcx_reg;
            m_reg[5] <= tda_pkg::mul30(sz_reg, sycx_reg) - czsx_reg;
            m_reg[6] <= -sy_reg;
            m_reg[7] <= cysx_reg;
            m_reg[8] <= cycx_reg;

            // align entries with the snapped delta
            ma_reg <= m_reg;
            mb_reg <= ma_reg;
        end
    end

    // ---------------- start transform delay line ----------------
    xf_t xf_in;
    xf_t dly_reg [0:SL];

    assign xf_in.loc = {s_start_loc_z, s_start_loc_y, s_start_loc_x};
    assign xf_in.rot = {s_start_rot_z, s_start_rot_y, s_start_rot_x};
    assign xf_in.scl = {s_start_scale_z, s_start_scale_y, s_start_scale_x};

    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_reg[0] <= xf_in;
            for (int k = 1; k <= SL; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // ---------------- products and sums ----------------
    logic signed [64:0] prod_reg  [9];
    logic signed [64:0] sprod_reg [3];
    logic               sneg_reg  [3];
    tda_pkg::word_t     rsum_reg  [3];
    tda_pkg::word_t     lsum_reg  [3];
    logic signed [32:0] f_grow    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_grow[i] = 33'sd65536 + 33'(dsn[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r*3+c] <= 65'(mb_reg[r*3+c]) * 65'(dsn[c]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                sprod_reg[i] <= 65'($signed(dly_reg[SL-1].scl[i])) * 65'(f_grow[i]);
                sneg_reg[i]  <= dly_reg[SL-1].scl[i][31] != f_grow[i][32];
                rsum_reg[i]  <= tda_pkg::sat_word(
                    68'(33'($signed(dly_reg[SL-1].rot[i])) + 33'(dsn[i])));
                lsum_reg[i]  <= tda_pkg::sat_word(
                    68'(33'($signed(dly_reg[SL-1].loc[i])) + 33'(dsn[i])));
            end
        end
    end

    // ---------------- output stage ----------------
    tda_pkg::word_t loc_next [3];
    tda_pkg::word_t rot_next [3];
    tda_pkg::word_t scl_next [3];
    tda_pkg::word_t loc_out_reg [3];
    tda_pkg::word_t rot_out_reg [3];
    tda_pkg::word_t scl_out_reg [3];
    logic signed [66:0] dsum [3];
    logic signed [64:0] srnd [3];
    tda_pkg::word_t     dot  [3];
    tda_pkg::word_t     scl_new [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dsum[i] = 67'(prod_reg[i*3]) + 67'(prod_reg[i*3+1]) + 67'(prod_reg[i*3+2])
                      + 67'sd536870912;
            dsum[i] = dsum[i] >>> 30;
            dot[i]  = tda_pkg::sat_word(68'(dsum[i]));

            srnd[i] = (sprod_reg[i] + 65'sd32768) >>> tda_pkg::FRAC_BITS;
            scl_new[i] = tda_pkg::sat_word(68'(srnd[i]));
            // never let a scale collapse to zero
            if (scl_new[i] == '0) begin
                scl_new[i] = sneg_reg[i] ? -32'sd1 : 32'sd1;
            end

            loc_next[i] = $signed(dly_reg[SL].loc[i]);
            rot_next[i] = $signed(dly_reg[SL].rot[i]);
            scl_next[i] = $signed(dly_reg[SL].scl[i]);
            priority if (is_trans) begin
                loc_next[i] = space_reg
                    ? tda_pkg::sat_word(68'(33'($signed(dly_reg[SL].loc[i])) + 33'(dot[i])))
                    : lsum_reg[i];
            end else if (is_rot) begin
                rot_next[i] = rsum_reg[i];
            end else begin
                scl_next[i] = scl_new[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            loc_out_reg <= loc_next;
            rot_out_reg <= rot_next;
            scl_out_reg <= scl_next;
        end
    end

    assign m_new_loc_x   = loc_out_reg[0];
    assign m_new_loc_y   = loc_out_reg[1];
    assign m_new_loc_z   = loc_out_reg[2];
    assign m_new_rot_x   = rot_out_reg[0];
    assign m_new_rot_y   = rot_out_reg[1];
    assign m_new_rot_z   = rot_out_reg[2];
    assign m_new_scale_x = scl_out_reg[0];
    assign m_new_scale_y = scl_out_reg[1];
    assign m_new_scale_z = scl_out_reg[2];

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output register");

    a_no_loss_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $countones(vld_reg) == $past($countones(vld_reg)))
        else $error("transaction count changed during stall");

    a_scale_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && is_scale |->
            m_new_scale_x != '0 && m_new_scale_y != '0 && m_new_scale_z != '0)
        else $error("scale result is zero");

endmodule
